// File: rtl/phtfr_pkg.sv
// phtfr_pkg: types, constants and register codes for the pixel hit type filter
// and remapper; used by the channel interfaces and the top level
`default_nettype none

package phtfr_pkg;

	// fixed field widths
	localparam int unsigned SID_W    = 6;
	localparam int unsigned POS_W    = 9;
	localparam int unsigned CHARGE_W = 32;
	localparam int unsigned NCOL_W   = 12;
	localparam int unsigned CFG_W    = 9;
	localparam int unsigned CFG_IDX_W = 3;

	// grid geometry
	localparam logic [POS_W-1:0] FIRST_ROW   = POS_W'(1);
	localparam int unsigned      RECT_PERIOD = 3;
	localparam int unsigned      HEX_PERIOD  = 4;

	// region types
	typedef enum logic [1:0] {
		TYPE_OFF  = 2'd0,
		TYPE_FE   = 2'd1,
		TYPE_RECT = 2'd2,
		TYPE_HEX  = 2'd3
	} region_type_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SELECTED_TYPE    = 3'd0,
		CFG_LAYOUT_FIRST_COL = 3'd1,
		CFG_METAL_FIRST_COL  = 3'd2,
		CFG_METAL_LAST_COL   = 3'd3,
		CFG_METAL_FIRST_ROW  = 3'd4,
		CFG_METAL_END_ROW    = 3'd5,
		CFG_HEX_FIRST_ROW    = 3'd6,
		CFG_LAYOUT_LAST_ROW  = 3'd7
	} cfg_reg_t;

	// input transaction
	typedef struct packed {
		logic                hit_present;
		logic [SID_W-1:0]    sensor_id;
		logic [POS_W-1:0]    col;
		logic [POS_W-1:0]    row;
		logic [CHARGE_W-1:0] charge_word;
		logic                frame_last;
	} hit_in_t;

	// result transaction
	typedef struct packed {
		logic [SID_W-1:0]         out_sensor_id;
		logic                     hit_valid;
		logic signed [NCOL_W-1:0] new_col;
		logic [POS_W-1:0]         new_row;
		logic [CHARGE_W-1:0]      out_charge_word;
		logic                     out_frame_last;
	} hit_out_t;

endpackage

`default_nettype wire

// File: rtl/phtfr_if.sv
// phtfr_if: valid/ready channel interfaces for hit input and result output
// depends on phtfr_pkg for the payload types
`default_nettype none

interface phtfr_in_if;
	import phtfr_pkg::*;
	logic    valid;
	logic    ready;
	hit_in_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface phtfr_out_if;
	import phtfr_pkg::*;
	logic     valid;
	logic     ready;
	hit_out_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/pixel_hit_type_filter_remap_top.sv
// pixel_hit_type_filter_remap_top: sorts hits into region types, keeps the
// selected type and remaps kept hits onto the grid; uses phtfr_pkg, phtfr_if
//
// channel    dir   carries
// in_ch      in    hit_present, sensor_id, col, row, charge_word, frame_last
// out_ch     out   out_sensor_id, hit_valid, new_col, new_row, out_charge_word,
//                  out_frame_last
// cfg_*      in    write enable, register index, 9-bit write data
//
// one transaction per cycle sustained while the output side is not stalled; a result
// passes through the input register, then the result register
// dropped hits that do not close a frame give no result and leave stage one
// without waiting for the output side
// reset clears valid flags and loads the configuration defaults
// a stalled result holds in the output register while stage one still fills
`default_nettype none

module pixel_hit_type_filter_remap_top (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	phtfr_in_if.sink                                in_ch,
	phtfr_out_if.source                             out_ch,
	input  wire logic                               cfg_we,
	input  wire logic [phtfr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [phtfr_pkg::CFG_W-1:0]        cfg_wdata
);
	import phtfr_pkg::*;

	// configuration registers
	region_type_t     sel_type_q;
	logic [POS_W-1:0] layout_first_col_q;
	logic [POS_W-1:0] metal_first_col_q;
	logic [POS_W-1:0] metal_last_col_q;
	logic [POS_W-1:0] metal_first_row_q;
	logic [POS_W-1:0] metal_end_row_q;
	logic [POS_W-1:0] hex_first_row_q;
	logic [POS_W-1:0] layout_last_row_q;

	// pipeline
	logic     v_s1;
	hit_in_t  hit_s1;
	logic     out_v_q;
	hit_out_t out_q;

	// datapath
	region_type_t             rtype;
	logic                     kept;
	logic                     emit;
	logic signed [NCOL_W-1:0] col_new;
	logic [POS_W-1:0]         row_new;
	logic                     out_free;
	logic                     s1_go;
	logic                     in_take;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_type_q         <= TYPE_RECT;
			layout_first_col_q <= POS_W'(1);
			metal_first_col_q  <= POS_W'(9);
			metal_last_col_q   <= POS_W'(72);
			metal_first_row_q  <= POS_W'(1);
			metal_end_row_q    <= POS_W'(300);
			hex_first_row_q    <= POS_W'(150);
			layout_last_row_q  <= POS_W'(336);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_SELECTED_TYPE:    sel_type_q         <= region_type_t'(cfg_wdata[1:0]);
				CFG_LAYOUT_FIRST_COL: layout_first_col_q <= cfg_wdata;
				CFG_METAL_FIRST_COL:  metal_first_col_q  <= cfg_wdata;
				CFG_METAL_LAST_COL:   metal_last_col_q   <= cfg_wdata;
				CFG_METAL_FIRST_ROW:  metal_first_row_q  <= cfg_wdata;
				CFG_METAL_END_ROW:    metal_end_row_q    <= cfg_wdata;
				CFG_HEX_FIRST_ROW:    hex_first_row_q    <= cfg_wdata;
				CFG_LAYOUT_LAST_ROW:  layout_last_row_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// region classification, first matching rule wins
	always_comb begin
		logic metal_cols;
		metal_cols = (hit_s1.col >= metal_first_col_q) && (hit_s1.col <= metal_last_col_q);
		if ((hit_s1.col >= layout_first_col_q) && (hit_s1.col < metal_first_col_q) &&
		    (hit_s1.row >= FIRST_ROW) && (hit_s1.row <= layout_last_row_q))
			rtype = TYPE_FE;
		else if (metal_cols && (hit_s1.row >= metal_end_row_q) &&
		         (hit_s1.row <= layout_last_row_q))
			rtype = TYPE_FE;
		else if (metal_cols && (hit_s1.row >= metal_first_row_q) &&
		         (hit_s1.row < hex_first_row_q))
			rtype = TYPE_RECT;
		else if (metal_cols && (hit_s1.row >= hex_first_row_q) &&
		         (hit_s1.row < metal_end_row_q))
			rtype = TYPE_HEX;
		else
			rtype = TYPE_OFF;
	end

	assign kept = hit_s1.hit_present && (rtype == sel_type_q);
	assign emit = kept || hit_s1.frame_last;

	// grid remap of the column and row
	always_comb begin
		logic [POS_W-1:0]         d_even;
		logic [POS_W:0]           d_odd;
		logic [POS_W:0]           d_hex;
		logic signed [NCOL_W-1:0] r_base;
		logic signed [NCOL_W-1:0] r_lb;
		logic signed [NCOL_W-1:0] h_base;
		logic signed [NCOL_W-1:0] h_lb;
		logic                     x_odd;
		logic                     even_dc;
		logic                     y_even;
		logic                     first;
		logic [1:0]               ph;
		logic [POS_W:0]           y_inc;

		// double-column offsets from the first metallized column
		d_even  = hit_s1.col - metal_first_col_q;
		d_odd   = {1'b0, hit_s1.col} - {1'b0, metal_first_col_q} + (POS_W+1)'(1);
		r_base  = NCOL_W'(d_even[POS_W-1:1]) * NCOL_W'(RECT_PERIOD);
		r_lb    = NCOL_W'(d_odd[POS_W:1]) * NCOL_W'(RECT_PERIOD) - NCOL_W'(1);
		h_base  = NCOL_W'(d_even[POS_W-1:1]) * NCOL_W'(HEX_PERIOD);
		h_lb    = NCOL_W'(d_odd[POS_W:1]) * NCOL_W'(HEX_PERIOD);
		x_odd   = hit_s1.col[0];
		// even double column: bit one of col for odd col, inverted for even col
		even_dc = x_odd ? hit_s1.col[1] : ~hit_s1.col[1];
		y_even  = ~hit_s1.row[0];
		first   = (hit_s1.row == FIRST_ROW);
		d_hex   = {1'b0, hit_s1.row} - {1'b0, hex_first_row_q};
		ph      = d_hex[1:0];
		y_inc   = {1'b0, hit_s1.row} + (POS_W+1)'(1);

		col_new = NCOL_W'(hit_s1.col);
		row_new = hit_s1.row;
		case (rtype)
			TYPE_RECT: begin
				row_new = y_inc[POS_W:1];
				if (!x_odd) begin
					if (even_dc)
						col_new = y_even ? (first ? r_base : r_base + NCOL_W'(2))
						                 : r_base + NCOL_W'(1);
					else
						col_new = y_even ? (first ? r_base : r_base + NCOL_W'(1)) : r_base;
				end else begin
					if (even_dc)
						col_new = y_even ? (first ? r_lb : r_lb - NCOL_W'(2))
						                 : r_lb - NCOL_W'(1);
					else
						col_new = y_even ? (first ? r_lb : r_lb - NCOL_W'(1)) : r_lb;
				end
			end
			TYPE_HEX: begin
				row_new = d_hex[POS_W:1];
				if (!x_odd) begin
					case (ph)
						2'd0:    col_new = h_base + NCOL_W'(1);
						2'd1:    col_new = h_base;
						2'd2:    col_new = even_dc ? h_base + NCOL_W'(1) : h_base;
						default: col_new = even_dc ? h_base : h_base + NCOL_W'(1);
					endcase
				end else begin
					case (ph)
						2'd0:    col_new = h_lb - NCOL_W'(2);
						2'd1:    col_new = h_lb - NCOL_W'(1);
						2'd2:    col_new = even_dc ? h_lb - NCOL_W'(2) : h_lb - NCOL_W'(1);
						default: col_new = even_dc ? h_lb - NCOL_W'(1) : h_lb - NCOL_W'(2);
					endcase
				end
			end
			default: begin
				col_new = NCOL_W'(hit_s1.col);
				row_new = hit_s1.row;
			end
		endcase
	end

	// flow control
	assign out_free    = !out_v_q || out_ch.ready;
	assign s1_go       = v_s1 && (!emit || out_free);
	assign in_ch.ready = !v_s1 || s1_go;
	assign in_take     = in_ch.valid && in_ch.ready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (in_take)
			v_s1 <= 1'b1;
		else if (s1_go)
			v_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_take)
			hit_s1 <= in_ch.data;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_v_q <= 1'b0;
		else if (s1_go && emit)
			out_v_q <= 1'b1;
		else if (out_ch.ready)
			out_v_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (s1_go && emit) begin
			out_q.out_sensor_id   <= hit_s1.sensor_id;
			out_q.hit_valid       <= kept;
			out_q.new_col         <= kept ? col_new : '0;
			out_q.new_row         <= kept ? row_new : '0;
			out_q.out_charge_word <= kept ? hit_s1.charge_word : '0;
			out_q.out_frame_last  <= hit_s1.frame_last;
		end
	end

	assign out_ch.valid = out_v_q;
	assign out_ch.data  = out_q;

	// a result without a kept hit only closes a frame
	a_empty_is_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !out_q.hit_valid |-> out_q.out_frame_last)
		else $error("result without hit does not close a frame");

	// a result without a kept hit carries a cleared payload
	a_empty_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !out_q.hit_valid |->
			(out_q.new_col == '0) && (out_q.new_row == '0) && (out_q.out_charge_word == '0))
		else $error("result without hit carries stale payload");

	// an accepted transaction always lands in stage one
	a_take_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> v_s1)
		else $error("accepted transaction lost before stage one");

	// a result leaves stage one only into a free output register
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !out_ch.ready |=> $stable(out_q))
		else $error("stalled result overwritten");

endmodule

`default_nettype wire
